// ===== design/edd_pkg.sv =====
package edd_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int ERR_FB     = 8;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = 13;
   localparam int SAMPLE_W   = 20;
   localparam int CODE_W     = 16;
   localparam int ERR_W      = 18 + ERR_FB;
   localparam int X_W        = SAMPLE_W + ERR_FB + 2;
   localparam int CODE_RAW_W = X_W - ERR_FB - 4;
   localparam int E_W        = X_W + 1;
   localparam int ERR_SAT    = 2 ** (15 + ERR_FB);
   localparam int ROUND_HALF = 2 ** (ERR_FB + 3);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CODE   = 2'd1;

   localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(MAX_WIDTH);
   localparam logic [CODE_W-1:0]  MAX_CODE_RESET   = CODE_W'(255);

endpackage

// ===== design/edd_ram.sv =====
module edd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/error_diffusion_dither.sv =====
// Floyd-Steinberg error diffusion dither for a raster pixel stream.
// The req channel carries one pixel per transfer: req_sample is the pixel in
// output code units with 4 fraction bits, and req_frame_start marks the first
// pixel of a frame. The rsp channel returns one quantized code per pixel, in
// order. The csr channel writes line_width (index 0) and max_code (index 1);
// csr_ready is always high. The user must make writes only while no pixel
// is in flight; the block does not enforce this. Pixels pass the compute
// stage and output registers in order, one pixel per cycle when not stalled.
// The row of errors lives in a single-port-write, registered-read memory that
// is read one column ahead; a write and a read of the same column at one edge
// are forwarded, so there is no bubble at any line width.
// Reset clears the pipeline, sets line_width to 4096 and max_code to 255 and
// starts in the first row of a frame. The memory is not cleared: the first
// row never reads it. When rsp_ready is low the output register holds its
// code, one more pixel may enter the compute stage, and req_ready then falls
// until the output is taken.
module error_diffusion_dither (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [edd_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [edd_pkg::CODE_W-1:0]        rsp_code,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [edd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [edd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import edd_pkg::*;

   logic [WIDTH_W-1:0] line_width_ff;
   logic [CODE_W-1:0]  max_code_ff;
   logic [WIDTH_W-1:0] width;

   logic [COL_W-1:0] column_ff, column_in;
   logic             first_row_ff, first_row_in;

   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_first_ff;
   logic                s1_ar_ok_ff;
   logic                fwd_ff;
   logic signed [ERR_W-1:0] fwd_data_ff;

   logic signed [ERR_W-1:0] left_ff;
   logic signed [ERR_W-1:0] above_ff;
   logic signed [ERR_W-1:0] above_left_ff;
   logic signed [ERR_W-1:0] row0_err_ff;

   logic              rsp_valid_ff;
   logic [CODE_W-1:0] rsp_code_ff;

   logic             req_fire, s1_fire;
   logic [COL_W-1:0] col_start, col_j, rd_addr;
   logic             first_start, first_j, wrap, last, ar_ok;

   logic [ERR_W-1:0]        ram_rdata;
   logic signed [ERR_W-1:0] ar_raw, ar, a, l, al, e_sat;
   logic signed [X_W-1:0]   sum, x, xr;
   logic [CODE_RAW_W-1:0]   code_raw;
   logic [CODE_W-1:0]       code;
   logic signed [E_W-1:0]   e_full, e_trunc;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         max_code_ff   <= MAX_CODE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_MAX_CODE:   max_code_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (line_width_ff == '0) begin
         width = WIDTH_W'(1);
      end else if (line_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         width = WIDTH_W'(MAX_WIDTH);
      end else begin
         width = line_width_ff;
      end
   end

   // Column bookkeeping for the incoming pixel.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   assign col_start   = req_frame_start ? '0 : column_ff;
   assign first_start = req_frame_start | first_row_ff;
   assign wrap        = {1'b0, col_start} >= width;
   assign col_j       = wrap ? '0 : col_start;
   assign first_j     = wrap ? 1'b0 : first_start;
   assign last        = ({1'b0, col_j} + WIDTH_W'(1)) >= width;
   assign ar_ok       = !first_j && !last;
   assign rd_addr     = col_j + COL_W'(1);
   assign column_in    = last ? '0 : rd_addr;
   assign first_row_in = last ? 1'b0 : first_j;

   edd_ram #(
      .WIDTH(ERR_W),
      .DEPTH(MAX_WIDTH)
   ) u_err_line (
      .clock  (clock),
      .wr_en  (s1_fire),
      .wr_addr(s1_col_ff),
      .wr_data(e_sat),
      .rd_en  (req_fire),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

   // Compute stage: weighted error, rounding, clamping and the new error.
   always_comb begin
      ar_raw = fwd_ff ? fwd_data_ff : $signed(ram_rdata);
      ar     = s1_ar_ok_ff ? ar_raw : '0;
      if (s1_col_ff == '0) begin
         l  = '0;
         a  = s1_first_ff ? '0 : row0_err_ff;
         al = '0;
      end else begin
         l  = left_ff;
         a  = s1_first_ff ? '0 : above_ff;
         al = s1_first_ff ? '0 : above_left_ff;
      end
      sum = X_W'(l) * X_W'(7) + X_W'(ar) * X_W'(3) + X_W'(a) * X_W'(5) + X_W'(al);
      x   = $signed({2'b00, s1_sample_ff, {ERR_FB{1'b0}}}) + sum;
      xr  = x + X_W'(ROUND_HALF);
      code_raw = xr[X_W-1:ERR_FB+4];
      if (xr <= 0) begin
         code = '0;
      end else if (code_raw > CODE_RAW_W'(max_code_ff)) begin
         code = max_code_ff;
      end else begin
         code = code_raw[CODE_W-1:0];
      end
      e_full = E_W'(x) - $signed(E_W'({code, {(ERR_FB + 4){1'b0}}}));
      if (e_full < 0) begin
         e_trunc = (e_full + E_W'(15)) >>> 4;
      end else begin
         e_trunc = e_full >>> 4;
      end
      if (e_trunc > E_W'(ERR_SAT)) begin
         e_sat = ERR_W'(ERR_SAT);
      end else if (e_trunc < -E_W'(ERR_SAT)) begin
         e_sat = -ERR_W'(ERR_SAT);
      end else begin
         e_sat = e_trunc[ERR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff       <= '0;
         above_ff      <= '0;
         above_left_ff <= '0;
         row0_err_ff   <= '0;
         fwd_ff        <= 1'b0;
      end else begin
         if (req_fire) begin
            column_ff    <= column_in;
            first_row_ff <= first_row_in;
            s1_sample_ff <= req_sample;
            s1_col_ff    <= col_j;
            s1_first_ff  <= first_j;
            s1_ar_ok_ff  <= ar_ok;
            fwd_ff       <= s1_fire && (s1_col_ff == rd_addr);
            fwd_data_ff  <= e_sat;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            left_ff       <= e_sat;
            above_ff      <= ar;
            above_left_ff <= a;
            if (s1_col_ff == '0) begin
               row0_err_ff <= e_sat;
            end
            rsp_code_ff  <= code;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = rsp_code_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import edd_pkg::*;

   localparam int RANDOM_ITEMS = 1030;
   localparam int HOLD_AFTER = 400;
   localparam int HOLD_CYCLES = 150;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_SPARSE, DRAIN_MOSTLY} drain_mode_type;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      logic [SAMPLE_W-1:0]   sample;
      logic                  frame_start;
      logic                  known;
      logic [CODE_W-1:0]     code;
   } plan_row_type;

   typedef struct packed {
      logic              known;
      logic [CODE_W-1:0] code;
   } pinned_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [SAMPLE_W-1:0] req_sample;
   logic req_frame_start;
   logic rsp_valid;
   logic rsp_ready;
   logic [CODE_W-1:0] rsp_code;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Dither state mirrored from the block.
   longint err_row [MAX_WIDTH];
   bit err_row_set [MAX_WIDTH];
   longint err_left;
   longint err_up;
   longint err_up_left;
   int unsigned col;
   bit top_row;
   logic [WIDTH_W-1:0] width_reg;
   logic [CODE_W-1:0] max_code_reg;

   logic [CODE_W-1:0] codes_due [$];
   pinned_type pinned_codes [$];
   plan_row_type plan [$];
   int failures;
   int pixels_in;
   int group_left;

   error_diffusion_dither u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code(rsp_code),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [CODE_W-1:0] dither_pixel(input logic [SAMPLE_W-1:0] s,
                                                      input logic fs);
      int unsigned w;
      int unsigned j;
      longint lt, up, up_r, up_l, x, xr, e;
      longint unsigned q;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      if (fs) begin
         col = 0;
         top_row = 1'b1;
      end
      if (col >= w) begin
         col = 0;
         top_row = 1'b0;
      end
      j = col;
      lt = (j == 0) ? 0 : err_left;
      if (top_row) begin
         up = 0;
         up_r = 0;
         up_l = 0;
      end else begin
         up = (j == 0) ? err_row[0] : err_up;
         up_r = (j + 1 < w) ? err_row[j + 1] : 0;
         up_l = (j == 0) ? 0 : err_up_left;
      end
      x = (longint'(s) <<< ERR_FB) + 7 * lt + 3 * up_r + 5 * up + up_l;
      xr = x + longint'(ROUND_HALF);
      if (xr <= 0) begin
         q = 0;
      end else begin
         q = xr >>> (ERR_FB + 4);
         if (q > max_code_reg) q = max_code_reg;
      end
      e = x - longint'(q << (ERR_FB + 4));
      e = (e >= 0) ? (e >>> 4) : -((-e) >>> 4);
      if (e > longint'(ERR_SAT)) e = ERR_SAT;
      if (e < -longint'(ERR_SAT)) e = -longint'(ERR_SAT);
      err_up_left = up;
      err_up = up_r;
      err_left = e;
      err_row[j] = e;
      err_row_set[j] = 1'b1;
      if (j + 1 >= w) begin
         col = 0;
         top_row = 1'b0;
      end else begin
         col = j + 1;
      end
      return q[CODE_W-1:0];
   endfunction

   always @(posedge clock) begin : watch_ports
      logic [CODE_W-1:0] want;
      pinned_type pin;
      logic [CODE_W-1:0] guess;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (codes_due.size() == 0) begin
               $error("rsp_code: no transfer expected, actual %0d", rsp_code);
               failures++;
            end else begin
               want = codes_due.pop_front();
               if (rsp_code !== want) begin
                  $error("rsp_code: expected %0d, actual %0d", want, rsp_code);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pin = pinned_codes.pop_front();
            guess = dither_pixel(req_sample, req_frame_start);
            codes_due.push_back(pin.known ? pin.code : guess);
            pixels_in++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINE_WIDTH: width_reg = csr_wdata[WIDTH_W-1:0];
               CSR_MAX_CODE: max_code_reg = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   initial begin : receiver
      drain_mode_type mode;
      int span;
      bit held;
      rsp_ready = 1'b0;
      held = 1'b0;
      forever begin
         if (!held && pixels_in >= HOLD_AFTER && group_left > 8) begin
            held = 1'b1;
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode = drain_mode_type'($urandom_range(0, 3));
         span = $urandom_range(4, 60);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               DRAIN_FREE: rsp_ready <= 1'b1;
               DRAIN_HALF: rsp_ready <= ($urandom_range(0, 1) == 1);
               DRAIN_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   function automatic void plan_csr(input logic [CSR_IDX_W-1:0] index,
                                    input logic [CSR_DATA_W-1:0] value);
      plan.push_back({1'b1, index, value, {SAMPLE_W{1'b0}}, 1'b0, 1'b0, {CODE_W{1'b0}}});
   endfunction

   function automatic void plan_pixel(input logic [SAMPLE_W-1:0] s, input logic fs);
      plan.push_back({1'b0, CSR_LINE_WIDTH, {CSR_DATA_W{1'b0}}, s, fs, 1'b0,
                      {CODE_W{1'b0}}});
   endfunction

   function automatic void plan_pinned(input logic [SAMPLE_W-1:0] s, input logic fs,
                                       input logic [CODE_W-1:0] code);
      plan.push_back({1'b0, CSR_LINE_WIDTH, {CSR_DATA_W{1'b0}}, s, fs, 1'b1, code});
   endfunction

   task automatic send_pixel(input logic [SAMPLE_W-1:0] s, input logic fs,
                             input logic known, input logic [CODE_W-1:0] code);
      @(negedge clock);
      pinned_codes.push_back({known, code});
      req_valid <= 1'b1;
      req_sample <= s;
      req_frame_start <= fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic settle_block();
      while (codes_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned new_w, n, burst, lim, k, sent, wide;
      bit start_fs;
      logic fs;
      logic [SAMPLE_W-1:0] s;
      logic [CODE_W-1:0] m;
      plan_row_type row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_frame_start = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_LINE_WIDTH;
      csr_wdata = '0;
      failures = 0;
      pixels_in = 0;
      group_left = 0;
      err_left = 0;
      err_up = 0;
      err_up_left = 0;
      col = 0;
      top_row = 1'b1;
      width_reg = LINE_WIDTH_RESET;
      max_code_reg = MAX_CODE_RESET;
      foreach (err_row[i]) begin
         err_row[i] = 0;
         err_row_set[i] = 1'b0;
      end

      plan_pinned(20'h00000, 1'b1, 16'd0);
      plan_pinned(20'hFFFFF, 1'b1, 16'd255);
      plan_pixel(20'h00000, 1'b0);
      plan_pinned(20'h00008, 1'b1, 16'd1);
      plan_pinned(20'h00007, 1'b1, 16'd0);
      plan_csr(CSR_LINE_WIDTH, 16'd4);
      plan_csr(CSR_MAX_CODE, 16'hFFFF);
      plan_pinned(20'hFFFFF, 1'b1, 16'hFFFF);
      plan_pixel(20'h00008, 1'b0);
      plan_pixel(20'h00000, 1'b0);
      plan_pixel(20'h5A5A5, 1'b0);
      plan_pixel(20'h00000, 1'b0);
      plan_pixel(20'h00008, 1'b0);
      plan_pixel(20'hFFFFF, 1'b0);
      plan_pixel(20'h00017, 1'b0);
      plan_pixel(20'h00100, 1'b0);
      plan_pixel(20'h00003, 1'b0);
      plan_csr(CSR_LINE_WIDTH, 16'hE001);
      plan_pixel(20'h00040, 1'b0);
      plan_pixel(20'h00040, 1'b0);
      plan_csr(CSR_LINE_WIDTH, 16'd0);
      plan_pixel(20'h00009, 1'b0);
      plan_csr(CSR_MAX_CODE, 16'd0);
      plan_pinned(20'hFFFFF, 1'b1, 16'd0);
      plan_pixel(20'h12345, 1'b0);
      plan_csr(CSR_SPARE, 16'hA5A5);
      plan_csr(CSR_LINE_WIDTH, 16'h1FFF);
      plan_csr(CSR_MAX_CODE, 16'h8000);
      plan_pixel(20'h3FFF0, 1'b1);
      plan_pixel(20'h00000, 1'b0);

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr) begin
            pause_sender(0);
            settle_block();
            csr_write(row.index, row.wdata);
         end else begin
            send_pixel(row.sample, row.frame_start, row.known, row.code);
         end
      end

      sent = 0;
      wide = 0;
      while (sent < RANDOM_ITEMS) begin
         pause_sender(0);
         settle_block();
         case ($urandom_range(0, 9))
            0: new_w = 1;
            1: new_w = 2;
            2, 3, 4, 5: new_w = $urandom_range(3, 16);
            6, 7: new_w = $urandom_range(17, 64);
            8: new_w = $urandom_range(65, 300);
            default: new_w = (wide < 2) ? MAX_WIDTH : $urandom_range(3, 16);
         endcase
         if (new_w == MAX_WIDTH) wide++;
         case ($urandom_range(0, 5))
            0: m = 16'd1;
            1: m = 16'd255;
            2: m = 16'hFFFF;
            3: m = CODE_W'($urandom_range(1, 1023));
            4: m = CODE_W'($urandom);
            default: m = CODE_W'($urandom_range(0, 16));
         endcase
         csr_write(CSR_LINE_WIDTH, CSR_DATA_W'(new_w)
                   | (CSR_DATA_W'($urandom_range(0, 7)) << WIDTH_W));
         csr_write(CSR_MAX_CODE, m);

         // Rows below the first read the stored errors, so a row wider than
         // what has been written since reset must open a new frame.
         k = 0;
         while (k < new_w && err_row_set[k]) k++;
         start_fs = (k < new_w) || ($urandom_range(0, 1) == 1);

         n = (new_w == MAX_WIDTH) ? 120 : $urandom_range(2 * new_w, 6 * new_w);
         if (n > 150) n = 150;
         if (n < 10) n = $urandom_range(10, 40);
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         group_left = int'(n);
         lim = (int'(m) + 1) * 16;
         if (lim > 20'hFFFFF) lim = 20'hFFFFF;
         burst = $urandom_range(1, 40);
         for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
               0: s = '0;
               1: s = '1;
               2: s = SAMPLE_W'($urandom);
               3: s = SAMPLE_W'(($urandom_range(0, m) << 4) + $urandom_range(7, 9));
               default: s = SAMPLE_W'($urandom_range(0, lim));
            endcase
            fs = (i == 0) ? start_fs : ($urandom_range(0, 39) == 0);
            send_pixel(s, fs, 1'b0, '0);
            sent++;
            group_left--;
            burst--;
            if (burst == 0) begin
               if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 10));
               burst = $urandom_range(1, 40);
            end
         end
      end

      pause_sender(0);
      settle_block();
      repeat (8) @(negedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
